/* rtl/bor_pkg.sv */
// bor_pkg: widths, constants and the divider cell payload type for the
// box overlap ratio block. No dependencies; every other file imports it.
package bor_pkg;

  // coordinate and fixed-point widths
  localparam int COORD_BITS    = 12;
  localparam int FRACTION_BITS = 16;

  // overlap ratio holds one integer bit above the fraction
  localparam int RATIO_BITS = FRACTION_BITS + 1;

  // signed box extent: right - left + 1 spans one bit more plus sign
  localparam int SPAN_BITS = COORD_BITS + 2;

  // signed area products
  localparam int PROD_BITS = 2 * SPAN_BITS;

  // unsigned denominator: a union of two full-frame boxes fits here
  localparam int DEN_BITS = 2 * (COORD_BITS + 1);

  // ratio of exactly one
  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRACTION_BITS;

  // payload handed from cell to cell along the divider chain
  typedef struct packed {
    logic [DEN_BITS:0]     rem;
    logic [DEN_BITS-1:0]   denom;
    logic [RATIO_BITS-1:0] quot;
    logic                  hit;
    logic                  degen;
  } bor_div_t;

endpackage

/* rtl/bor_if.sv */
// bor_if: valid/ready channel interfaces for box pair requests, overlap
// results and the cover mode configuration write. Depends on bor_pkg.

// box pair request channel
interface bor_box_if import bor_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] first_left;
  logic [COORD_BITS-1:0] first_top;
  logic [COORD_BITS-1:0] first_right;
  logic [COORD_BITS-1:0] first_bottom;
  logic [COORD_BITS-1:0] second_left;
  logic [COORD_BITS-1:0] second_top;
  logic [COORD_BITS-1:0] second_right;
  logic [COORD_BITS-1:0] second_bottom;

  modport source (
    output valid, first_left, first_top, first_right, first_bottom,
           second_left, second_top, second_right, second_bottom,
    input  ready
  );
  modport sink (
    input  valid, first_left, first_top, first_right, first_bottom,
           second_left, second_top, second_right, second_bottom,
    output ready
  );
endinterface

// overlap result channel
interface bor_res_if import bor_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RATIO_BITS-1:0] overlap;
  logic                  boxes_intersect;
  logic                  degenerate_flag;

  modport source (
    output valid, overlap, boxes_intersect, degenerate_flag,
    input  ready
  );
  modport sink (
    input  valid, overlap, boxes_intersect, degenerate_flag,
    output ready
  );
endinterface

// cover mode write channel
interface bor_cfg_if ();
  logic valid;
  logic ready;
  logic cover_mode;

  modport source (output valid, cover_mode, input ready);
  modport sink (input valid, cover_mode, output ready);
endinterface

/* rtl/bor_front.sv */
// bor_front: three-stage geometry front end (extents, areas, denominator)
// that prepares the first divider cell payload. Depends on bor_pkg, bor_if.
module bor_front import bor_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cover_mode,
  bor_box_if.sink   box,
  output logic      dn_valid,
  output bor_div_t  dn_data,
  input  logic      dn_ready
);

  localparam int PAD_BITS = SPAN_BITS - COORD_BITS;

  // stage handshake
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready  = !s3_valid_r || dn_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign box.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= box.valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  // stage 1: box extents and intersection extents
  logic [COORD_BITS-1:0] min_r, max_l, min_b, max_t;
  logic signed [SPAN_BITS-1:0] w1_nxt, h1_nxt, w2_nxt, h2_nxt, iw_nxt, ih_nxt;
  logic signed [SPAN_BITS-1:0] w1_r, h1_r, w2_r, h2_r, iw_r, ih_r;
  logic signed [SPAN_BITS-1:0] one_s;

  assign one_s = $signed(SPAN_BITS'(1));

  function automatic logic signed [SPAN_BITS-1:0] span(
    input logic [COORD_BITS-1:0] hi,
    input logic [COORD_BITS-1:0] lo
  );
    logic signed [SPAN_BITS-1:0] hi_s, lo_s;
    hi_s = $signed({{PAD_BITS{1'b0}}, hi});
    lo_s = $signed({{PAD_BITS{1'b0}}, lo});
    return hi_s - lo_s + $signed(SPAN_BITS'(1));
  endfunction

  always_comb begin
    min_r  = (box.first_right  < box.second_right)  ? box.first_right  : box.second_right;
    max_l  = (box.first_left   > box.second_left)   ? box.first_left   : box.second_left;
    min_b  = (box.first_bottom < box.second_bottom) ? box.first_bottom : box.second_bottom;
    max_t  = (box.first_top    > box.second_top)    ? box.first_top    : box.second_top;
    w1_nxt = span(box.first_right, box.first_left);
    h1_nxt = span(box.first_bottom, box.first_top);
    w2_nxt = span(box.second_right, box.second_left);
    h2_nxt = span(box.second_bottom, box.second_top);
    iw_nxt = span(min_r, max_l);
    ih_nxt = span(min_b, max_t);
  end

  always_ff @(posedge clk) begin
    if (s1_ready && box.valid) begin
      w1_r <= w1_nxt;
      h1_r <= h1_nxt;
      w2_r <= w2_nxt;
      h2_r <= h2_nxt;
      iw_r <= iw_nxt;
      ih_r <= ih_nxt;
    end
  end

  // stage 2: areas and intersection test
  logic signed [PROD_BITS-1:0] a1_r, a2_r, inter_r;
  logic hit_r;

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      a1_r    <= PROD_BITS'(w1_r) * PROD_BITS'(h1_r);
      a2_r    <= PROD_BITS'(w2_r) * PROD_BITS'(h2_r);
      inter_r <= PROD_BITS'(iw_r) * PROD_BITS'(ih_r);
      hit_r   <= (iw_r >= one_s) && (ih_r >= one_s);
    end
  end

  // stage 3: denominator select and degenerate check
  logic signed [PROD_BITS:0] den_s;
  logic     degen_nxt;
  bor_div_t div_nxt, div_r;

  always_comb begin
    if (cover_mode) begin
      den_s = (PROD_BITS+1)'(a2_r);
    end else begin
      den_s = (PROD_BITS+1)'(a1_r) + (PROD_BITS+1)'(a2_r) - (PROD_BITS+1)'(inter_r);
    end
    degen_nxt     = hit_r && (den_s[PROD_BITS] || (den_s == '0));
    div_nxt.hit   = hit_r;
    div_nxt.degen = degen_nxt;
    div_nxt.quot  = '0;
    // no usable quotient: divide zero by one so the chain yields zero
    if (hit_r && !degen_nxt) begin
      div_nxt.rem   = {1'b0, inter_r[DEN_BITS-1:0]};
      div_nxt.denom = den_s[DEN_BITS-1:0];
    end else begin
      div_nxt.rem   = '0;
      div_nxt.denom = DEN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      div_r <= div_nxt;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_data  = div_r;

endmodule

/* rtl/bor_div_cell.sv */
// bor_div_cell: one restoring division step, one quotient bit per cell,
// with its own valid/ready stage. Depends on bor_pkg.
module bor_div_cell import bor_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  bor_div_t up_data,
  output logic     up_ready,
  output logic     dn_valid,
  output bor_div_t dn_data,
  input  logic     dn_ready
);

  logic     valid_r;
  bor_div_t data_r, data_nxt;
  logic     ge;
  logic [DEN_BITS:0] res;

  assign up_ready = !valid_r || dn_ready;

  // trial subtract, keep the remainder, shift it for the next cell
  always_comb begin
    ge            = up_data.rem >= {1'b0, up_data.denom};
    res           = ge ? (up_data.rem - {1'b0, up_data.denom}) : up_data.rem;
    data_nxt      = up_data;
    data_nxt.rem  = {res[DEN_BITS-1:0], 1'b0};
    data_nxt.quot = {up_data.quot[RATIO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* rtl/box_overlap_ratio_top.sv */
// box_overlap_ratio_top: top level, geometry front end followed by a chain
// of divider cells. Depends on bor_pkg, bor_if, bor_front, bor_div_cell.
//
// Usage:
//   in_box  - box pair requests (inclusive corners), valid/ready.
//   out_res - overlap ratio (unsigned, FRACTION_BITS fraction bits,
//             truncated), intersect flag and degenerate flag, valid/ready.
//   cfg_wr  - cover_mode write, always ready; 1 divides by the second box
//             area, 0 by the union area. Write it only while idle.
// Pipeline: 3 front-end stages plus RATIO_BITS divider cells, request
// to result. Throughput: one request per cycle while out_res is not
// stalled; each divider cell resolves one quotient bit and hands its
// remainder to the next cell every cycle unless stalled.
// Every stage has its own valid bit and ready, so a stalled receiver
// holds the last cell while empty stages upstream keep taking requests;
// in_box.ready drops only once the whole chain is full.
// Reset clears all stage valid bits and sets cover_mode to 0.
module box_overlap_ratio_top import bor_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  bor_box_if.sink in_box,
  bor_res_if.source out_res,
  bor_cfg_if.sink cfg_wr
);

  // configuration register
  logic cover_mode_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cover_mode_r <= 1'b0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      cover_mode_r <= cfg_wr.cover_mode;
    end
  end

  // divider chain links
  logic     chain_valid [0:RATIO_BITS];
  logic     chain_ready [0:RATIO_BITS];
  bor_div_t chain_data  [0:RATIO_BITS];

  bor_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cover_mode (cover_mode_r),
    .box        (in_box),
    .dn_valid   (chain_valid[0]),
    .dn_data    (chain_data[0]),
    .dn_ready   (chain_ready[0])
  );

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < RATIO_BITS; k++) begin : g_cell
    bor_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_data  (chain_data[k]),
      .up_ready (chain_ready[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_data  (chain_data[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  // last cell register is the output register
  assign chain_ready[RATIO_BITS] = out_res.ready;
  assign out_res.valid           = chain_valid[RATIO_BITS];
  assign out_res.overlap         = chain_data[RATIO_BITS].quot;
  assign out_res.boxes_intersect = chain_data[RATIO_BITS].hit;
  assign out_res.degenerate_flag = chain_data[RATIO_BITS].degen;

  // no intersection gives a clean zero result
  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.boxes_intersect |->
      (out_res.overlap == '0) && !out_res.degenerate_flag)
    else $error("non-intersecting pair with nonzero result");

  // degenerate denominator forces zero and implies an intersection
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.degenerate_flag |->
      (out_res.overlap == '0) && out_res.boxes_intersect)
    else $error("degenerate result with nonzero overlap");

  // ratio never exceeds one
  a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.overlap <= RATIO_ONE)
    else $error("overlap ratio above one");

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for box_overlap_ratio_top, a directed table then
// random box pairs checked against a local overlap predictor.
// Depends on bor_pkg, bor_if and the box_overlap_ratio_top rtl.
module tb;
  import bor_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_COVER = 1'b1;
  localparam int   COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int   PIPE_LAT   = 3 + RATIO_BITS;
  localparam int   SEG_ITEMS  = 188;

  typedef struct packed {
    logic [COORD_BITS-1:0] first_left;
    logic [COORD_BITS-1:0] first_top;
    logic [COORD_BITS-1:0] first_right;
    logic [COORD_BITS-1:0] first_bottom;
    logic [COORD_BITS-1:0] second_left;
    logic [COORD_BITS-1:0] second_top;
    logic [COORD_BITS-1:0] second_right;
    logic [COORD_BITS-1:0] second_bottom;
  } box_pair_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] overlap;
    logic                  hit;
    logic                  degen;
  } overlap_res_t;

  typedef struct {
    logic         mode;
    box_pair_t    boxes;
    bit           pinned;
    overlap_res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bor_box_if box_if ();
  bor_res_if res_if ();
  bor_cfg_if cfg_if ();

  box_overlap_ratio_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_box  (box_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  // expected overlap results in request order
  overlap_res_t overlap_due_q[$];
  dir_row_t     dir_rows[$];
  logic         cover_mode_q;
  bit           drv_pinned;
  overlap_res_t drv_want;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           errors;
  int           results_seen;

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // overlap predictor: inclusive corners, ratio truncated to fixed point
  function automatic overlap_res_t calc_overlap(box_pair_t p, logic mode);
    longint l1, t1, r1, b1, l2, t2, r2, b2;
    longint area1, area2, iw, ih, inter, denom;
    longint unsigned q;
    overlap_res_t r;
    l1 = longint'(p.first_left);   t1 = longint'(p.first_top);
    r1 = longint'(p.first_right);  b1 = longint'(p.first_bottom);
    l2 = longint'(p.second_left);  t2 = longint'(p.second_top);
    r2 = longint'(p.second_right); b2 = longint'(p.second_bottom);
    r = '0;
    area1 = (r1 - l1 + 1) * (b1 - t1 + 1);
    area2 = (r2 - l2 + 1) * (b2 - t2 + 1);
    iw = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2) + 1;
    ih = ((b1 < b2) ? b1 : b2) - ((t1 > t2) ? t1 : t2) + 1;
    if (iw > 0 && ih > 0) begin
      inter = iw * ih;
      denom = (mode == MODE_COVER) ? area2 : (area1 + area2 - inter);
      r.hit = 1'b1;
      // guard only: intersecting boxes are always proper
      if (denom <= 0) begin
        r.degen = 1'b1;
      end else begin
        q = (longint'(inter) << FRACTION_BITS) / longint'(denom);
        r.overlap = (q > RATIO_ONE) ? RATIO_ONE : q[RATIO_BITS-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  // mostly small extents, some wide, a few up to the full frame
  function automatic int rand_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 64);
    if (pick < 95) return $urandom_range(1, 1024);
    return $urandom_range(1, COORD_MAX + 1);
  endfunction

  // random box pair: mostly overlapping, then nested, edge, noise, inverted
  function automatic box_pair_t rand_pair();
    box_pair_t p;
    box_pair_t swapped;
    int kind, x0, y0, x1, y1, px, py;
    logic [COORD_BITS-1:0] tmp;
    kind = $urandom_range(0, 9);
    x0 = $urandom_range(0, COORD_MAX);
    y0 = $urandom_range(0, COORD_MAX);
    x1 = int'(clamp_coord(x0 + rand_len() - 1));
    y1 = int'(clamp_coord(y0 + rand_len() - 1));
    p.first_left   = x0[COORD_BITS-1:0];
    p.first_top    = y0[COORD_BITS-1:0];
    p.first_right  = x1[COORD_BITS-1:0];
    p.first_bottom = y1[COORD_BITS-1:0];
    // second box grown around a pixel of the first
    px = $urandom_range(x0, x1);
    py = $urandom_range(y0, y1);
    p.second_left   = clamp_coord(px - rand_len() + 1);
    p.second_right  = clamp_coord(px + rand_len() - 1);
    p.second_top    = clamp_coord(py - rand_len() + 1);
    p.second_bottom = clamp_coord(py + rand_len() - 1);
    case (kind)
      6: begin
        // nested, either way round
        p.second_left   = COORD_BITS'($urandom_range(x0, x1));
        p.second_right  = COORD_BITS'($urandom_range(p.second_left, x1));
        p.second_top    = COORD_BITS'($urandom_range(y0, y1));
        p.second_bottom = COORD_BITS'($urandom_range(p.second_top, y1));
        if ($urandom_range(0, 1) == 1) begin
          swapped = p;
          swapped.first_left    = p.second_left;
          swapped.first_top     = p.second_top;
          swapped.first_right   = p.second_right;
          swapped.first_bottom  = p.second_bottom;
          swapped.second_left   = p.first_left;
          swapped.second_top    = p.first_top;
          swapped.second_right  = p.first_right;
          swapped.second_bottom = p.first_bottom;
          p = swapped;
        end
      end
      7: begin
        // shared edge column or the column just past it
        p.second_left  = clamp_coord(x1 + $urandom_range(0, 1));
        p.second_right = clamp_coord(p.second_left + rand_len() - 1);
      end
      8: begin
        p = {$urandom, $urandom, $urandom};
      end
      9: begin
        // one box with swapped corners
        if ($urandom_range(0, 1) == 1) begin
          tmp = p.first_left;
          p.first_left  = p.first_right;
          p.first_right = tmp;
        end else begin
          tmp = p.second_top;
          p.second_top    = p.second_bottom;
          p.second_bottom = tmp;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic dir_row_t dir_row(logic mode, int l1, int t1, int r1, int b1,
                                       int l2, int t2, int r2, int b2,
                                       bit pinned, int ovl, bit hit);
    dir_row_t d;
    d.mode   = mode;
    d.boxes  = {clamp_coord(l1), clamp_coord(t1), clamp_coord(r1), clamp_coord(b1),
                clamp_coord(l2), clamp_coord(t2), clamp_coord(r2), clamp_coord(b2)};
    d.pinned = pinned;
    d.want   = {ovl[RATIO_BITS-1:0], hit, 1'b0};
    return d;
  endfunction

  // append one row to the directed table
  function automatic void add_row(dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  // drive one box pair request, entered and left at a falling edge
  task automatic push_box(box_pair_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      box_if.valid <= 1'b0;
      @(negedge clk);
    end
    box_if.first_left    <= p.first_left;
    box_if.first_top     <= p.first_top;
    box_if.first_right   <= p.first_right;
    box_if.first_bottom  <= p.first_bottom;
    box_if.second_left   <= p.second_left;
    box_if.second_top    <= p.second_top;
    box_if.second_right  <= p.second_right;
    box_if.second_bottom <= p.second_bottom;
    box_if.valid         <= 1'b1;
    do @(posedge clk); while (!box_if.ready);
    @(negedge clk);
  endtask

  // stop requests and wait for every outstanding result
  task automatic drain_results();
    box_if.valid <= 1'b0;
    while (overlap_due_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_mode(logic mode);
    cfg_if.cover_mode <= mode;
    cfg_if.valid      <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // receiver backpressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // request capture, mode tracking and result checking
  always @(posedge clk) begin
    overlap_res_t got;
    overlap_res_t due;
    box_pair_t    seen;
    if (!rst_n) begin
      cover_mode_q <= MODE_UNION;
    end else begin
      if (cfg_if.valid && cfg_if.ready) cover_mode_q <= cfg_if.cover_mode;
      if (res_if.valid && res_if.ready) begin
        got = {res_if.overlap, res_if.boxes_intersect, res_if.degenerate_flag};
        results_seen++;
        if (overlap_due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          due = overlap_due_q.pop_front();
          if (got !== due) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected overlap=%0d intersect=%0b degenerate=%0b, %s%0d %s%0b %s%0b",
                       results_seen, due.overlap, due.hit, due.degen,
                       "got overlap=", got.overlap, "intersect=", got.hit,
                       "degenerate=", got.degen);
          end
        end
      end
      if (box_if.valid && box_if.ready) begin
        seen = {box_if.first_left, box_if.first_top, box_if.first_right,
                box_if.first_bottom, box_if.second_left, box_if.second_top,
                box_if.second_right, box_if.second_bottom};
        overlap_due_q.insert(overlap_due_q.size(),
                             drv_pinned ? drv_want : calc_overlap(seen, cover_mode_q));
      end
    end
  end

  // stimulus
  initial begin
    logic seg_mode;
    rst_n             = 1'b0;
    box_if.valid      = 1'b0;
    box_if.first_left = '0; box_if.first_top = '0;
    box_if.first_right = '0; box_if.first_bottom = '0;
    box_if.second_left = '0; box_if.second_top = '0;
    box_if.second_right = '0; box_if.second_bottom = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.cover_mode = MODE_UNION;
    drv_pinned        = 1'b0;
    drv_want          = '0;
    send_idle_pct     = 17;
    recv_stall_pct    = 70;
    errors            = 0;
    results_seen      = 0;

    // union mode, the reset value
    add_row(dir_row(MODE_UNION, 0, 0, 0, 0, 0, 0, 0, 0, 1, 65536, 1));
    add_row(dir_row(MODE_UNION, 4095, 4095, 4095, 4095,
                    4095, 4095, 4095, 4095, 1, 65536, 1));
    add_row(dir_row(MODE_UNION, 0, 0, 4095, 4095, 0, 0, 4095, 4095, 1, 65536, 1));
    add_row(dir_row(MODE_UNION, 0, 0, 9, 9, 20, 20, 29, 29, 1, 0, 0));
    add_row(dir_row(MODE_UNION, 0, 0, 9, 9, 10, 0, 19, 9, 1, 0, 0));
    add_row(dir_row(MODE_UNION, 0, 0, 9, 9, 9, 0, 18, 9, 0, 0, 0));
    add_row(dir_row(MODE_UNION, 100, 100, 50, 50, 0, 0, 4095, 4095, 1, 0, 0));
    add_row(dir_row(MODE_UNION, 0, 0, 4095, 4095, 60, 70, 30, 20, 1, 0, 0));
    add_row(dir_row(MODE_UNION, 0, 0, 1, 0, 1, 0, 2, 0, 0, 0, 0));
    add_row(dir_row(MODE_UNION, 0, 0, 4095, 4095,
                    4095, 4095, 4095, 4095, 1, 0, 1));
    add_row(dir_row(MODE_UNION, 'h555, 'h2aa, 'haaa, 'hd55,
                    'h2aa, 'h555, 'hd55, 'haaa, 0, 0, 0));
    add_row(dir_row(MODE_UNION, 100, 200, 400, 500, 300, 250, 700, 450, 0, 0, 0));
    add_row(dir_row(MODE_UNION, 10, 10, 19, 19, 0, 0, 99, 99, 0, 0, 0));
    // cover mode
    add_row(dir_row(MODE_COVER, 10, 10, 19, 19, 0, 0, 99, 99, 0, 0, 0));
    add_row(dir_row(MODE_COVER, 0, 0, 99, 99, 10, 10, 19, 19, 1, 65536, 1));
    add_row(dir_row(MODE_COVER, 0, 0, 4095, 4095,
                    4095, 4095, 4095, 4095, 1, 65536, 1));
    add_row(dir_row(MODE_COVER, 4095, 4095, 4095, 4095,
                    0, 0, 4095, 4095, 1, 0, 1));
    add_row(dir_row(MODE_COVER, 0, 0, 9, 9, 20, 20, 29, 29, 1, 0, 0));
    add_row(dir_row(MODE_COVER, 0, 0, 1, 0, 1, 0, 2, 0, 1, 32768, 1));
    add_row(dir_row(MODE_COVER, 'h555, 'h2aa, 'haaa, 'hd55,
                    'h2aa, 'h555, 'hd55, 'haaa, 0, 0, 0));
    add_row(dir_row(MODE_COVER, 0, 0, 4095, 4095, 50, 50, 10, 10, 1, 0, 0));

    // synchronous reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, mode switched only while idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cover_mode_q) begin
        drain_results();
        write_mode(dir_rows[i].mode);
      end
      drv_pinned = dir_rows[i].pinned;
      drv_want   = dir_rows[i].want;
      push_box(dir_rows[i].boxes);
    end
    drv_pinned = 1'b0;

    // random requests: three idling profiles, each in both modes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 70 : 0;
      recv_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 17 : 0;
      for (int half = 0; half < 2; half++) begin
        seg_mode = (half == 0) ? MODE_UNION : MODE_COVER;
        drain_results();
        write_mode(seg_mode);
        repeat (SEG_ITEMS) push_box(rand_pair());
      end
    end

    // wait out the pipeline
    drain_results();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (errors == 0 && overlap_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
